[sv/fxa_pkg.sv]
// ----------------------------------------------------------------------------
// fxa_pkg: shared types and constants for the Q24.8 arithmetic unit
// operation codes and the per-cell control bundle carried down the chain
// ----------------------------------------------------------------------------
package fxa_pkg;

   localparam int unsigned OpWidth = 4;
   localparam int unsigned DataWidth = 32;
   localparam int unsigned IntWidth = 24;

   typedef enum logic [OpWidth-1:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_MIN = 4'd4,
      OP_MAX = 4'd5,
      OP_INC = 4'd6,
      OP_DEC = 4'd7,
      OP_I2F = 4'd8
   } op_type;

   // control that travels with a beat down the divider chain
   typedef struct packed {
      logic valid;
      logic is_div;
      logic neg;
      logic dz;
      logic [DataWidth-1:0] early;
      logic [1:0] cmp;
      logic eq;
   } ctl_type;

endpackage

[sv/fxa_div_cell.sv]
// ----------------------------------------------------------------------------
// fxa_div_cell: one restoring-division step of the divider chain
// produces one quotient bit per cell and hands the remainder onward
// ----------------------------------------------------------------------------
module fxa_div_cell #(
   parameter int unsigned RW = 34,
   parameter int unsigned NW = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  fxa_pkg::ctl_type     ctl_in,
   input  logic [RW-1:0]        rem_in,
   input  logic [NW-1:0]        num_in,
   input  logic [RW-1:0]        den_in,
   output fxa_pkg::ctl_type     ctl_out,
   output logic [RW-1:0]        rem_out,
   output logic [NW-1:0]        num_out,
   output logic [RW-1:0]        den_out
);

   logic [RW:0]   trial;
   logic [RW-1:0] shifted;
   logic          take;

   fxa_pkg::ctl_type ctl_ff;
   logic [RW-1:0]    rem_ff, den_ff, rem_in_c;
   logic [NW-1:0]    num_ff, num_in_c;

   // shift in next numerator bit, try to subtract the divisor
   assign shifted  = {rem_in[RW-2:0], num_in[NW-1]};
   assign trial    = {1'b0, shifted} - {1'b0, den_in};
   assign take     = !trial[RW];
   assign rem_in_c = take ? trial[RW-1:0] : shifted;
   assign num_in_c = {num_in[NW-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (advance) begin
         ctl_ff.is_div <= ctl_in.is_div;
         ctl_ff.neg    <= ctl_in.neg;
         ctl_ff.dz     <= ctl_in.dz;
         ctl_ff.early  <= ctl_in.early;
         ctl_ff.cmp    <= ctl_in.cmp;
         ctl_ff.eq     <= ctl_in.eq;
         rem_ff        <= rem_in_c;
         num_ff        <= num_in_c;
         den_ff        <= den_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign rem_out = rem_ff;
   assign num_out = num_ff;
   assign den_out = den_ff;

endmodule

[sv/fixed_point_q24_8_alu_unit.sv]
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit: Q24.8 fixed-point arithmetic unit
// add, sub, mul, div, min, max, inc, dec, int-to-fixed on raw operands
// ----------------------------------------------------------------------------
// usage:
//   req_ channel carries an opcode and two raw operands; rsp_ channel returns
//   the raw result, its integer part, compare flags and error flags.
//   a beat is accepted when valid is high and stall is low.
// path: every beat flows through one entry register, a chain of
//   32+FRAC_BITS+1 divider cells, one rounding/saturation register and the
//   output register. all operations share the same path so results stay
//   in order.
// throughput: one beat per cycle while not stalled; the chain moves as a
//   whole; each cell is one restoring-division step. the multiply runs in
//   the entry stage (32x32 magnitude product) and rides as the early result.
// stall: when rsp_stall holds a full output register the whole chain
//   freezes and req_stall rises; nothing is dropped.
// reset: synchronous, clears all valid bits; data registers are not reset.
module fixed_point_q24_8_alu_unit #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_operation,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_result_raw,
   output logic signed [23:0] rsp_integer_part,
   output logic        rsp_a_less,
   output logic        rsp_a_greater,
   output logic        rsp_a_equal,
   output logic        rsp_overflow,
   output logic        rsp_divide_by_zero
);

   localparam int unsigned DW = fxa_pkg::DataWidth;
   // dividend |a|<<FRAC, plus one extra bit for the half-bit of rounding
   localparam int unsigned NW = DW + FRAC_BITS + 1;
   localparam int unsigned RW = DW + 2;
   localparam int unsigned CELLS = NW;

   logic advance;
   logic out_free;

   // ---------------- entry stage: decode, compare, multiply ----------------
   logic [DW-1:0] mag_a, mag_b, ua, ub;
   logic          lt, gt, eq, neg;
   logic [2*DW-1:0] prod;
   logic [2*DW-1:0] prod_rnd;
   logic [DW-1:0] simple_r;
   logic          mul_ovf;
   logic [DW-1:0] mul_r;

   assign ua    = req_operand_a;
   assign ub    = req_operand_b;
   assign mag_a = req_operand_a[DW-1] ? (~ua + 1'b1) : ua;
   assign mag_b = req_operand_b[DW-1] ? (~ub + 1'b1) : ub;
   assign lt    = req_operand_a < req_operand_b;
   assign gt    = req_operand_a > req_operand_b;
   assign eq    = req_operand_a == req_operand_b;
   assign neg   = req_operand_a[DW-1] ^ req_operand_b[DW-1];

   always_comb begin
      simple_r = '0;
      unique case (req_operation)
         fxa_pkg::OP_ADD: simple_r = ua + ub;
         fxa_pkg::OP_SUB: simple_r = ua - ub;
         fxa_pkg::OP_MIN: simple_r = lt ? ua : ub;
         fxa_pkg::OP_MAX: simple_r = gt ? ua : ub;
         fxa_pkg::OP_INC: simple_r = ua + 1'b1;
         fxa_pkg::OP_DEC: simple_r = ua - 1'b1;
         fxa_pkg::OP_I2F: simple_r = ua << FRAC_BITS;
         default:         simple_r = '0;
      endcase
   end

   // entry registers
   logic            e_valid_ff, e_mul_ff, e_div_ff, e_neg_ff, e_dz_ff, e_eq_ff;
   logic [1:0]      e_cmp_ff;
   logic [DW-1:0]   e_simple_ff, e_ua_ff, e_mag_a_ff, e_mag_b_ff;
   logic [2*DW-1:0] e_prod_ff;

   assign prod = mag_a * mag_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= req_valid;
      end
      if (advance) begin
         e_mul_ff    <= req_operation == fxa_pkg::OP_MUL;
         e_div_ff    <= req_operation == fxa_pkg::OP_DIV;
         e_dz_ff     <= ub == '0;
         e_neg_ff    <= neg;
         e_eq_ff     <= eq;
         e_cmp_ff    <= {gt, lt};
         e_simple_ff <= simple_r;
         e_ua_ff     <= ua;
         e_mag_a_ff  <= mag_a;
         e_mag_b_ff  <= mag_b;
         e_prod_ff   <= prod;
      end
   end

   // multiply rounding and saturation after the product register
   function automatic logic [DW-1:0] sat_fn(input logic [2*DW-1:0] mag, input logic ng,
                                           output logic ovf);
      logic [DW-1:0] lo;
      lo  = mag[DW-1:0];
      ovf = 1'b0;
      if (ng) begin
         if (mag > {{DW{1'b0}}, 1'b1, {(DW-1){1'b0}}}) begin
            ovf = 1'b1;
            return {1'b1, {(DW-1){1'b0}}};
         end
         return ~lo + 1'b1;
      end
      if (mag > {{(DW+1){1'b0}}, {(DW-1){1'b1}}}) begin
         ovf = 1'b1;
         return {1'b0, {(DW-1){1'b1}}};
      end
      return lo;
   endfunction

   assign prod_rnd = (e_prod_ff + (2*DW)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
   always_comb mul_r = sat_fn(prod_rnd, e_neg_ff, mul_ovf);

   // ---------------- divider chain ----------------
   fxa_pkg::ctl_type ctl_c [CELLS+1];
   logic [RW-1:0]    rem_c [CELLS+1];
   logic [NW-1:0]    num_c [CELLS+1];
   logic [RW-1:0]    den_c [CELLS+1];
   logic [DW-1:0]    early_r;
   logic             early_ovf;

   always_comb begin
      early_r   = e_simple_ff;
      early_ovf = 1'b0;
      if (e_mul_ff) begin
         early_r   = mul_r;
         early_ovf = mul_ovf;
      end else if (e_div_ff) begin
         early_r = e_ua_ff;
      end
   end

   always_comb begin
      ctl_c[0].valid  = e_valid_ff;
      ctl_c[0].is_div = e_div_ff && !e_dz_ff;
      // for non-divide beats neg carries the multiply overflow flag
      ctl_c[0].neg    = e_div_ff ? e_neg_ff : early_ovf;
      ctl_c[0].dz     = e_div_ff && e_dz_ff;
      ctl_c[0].early  = early_r;
      ctl_c[0].cmp    = e_cmp_ff;
      ctl_c[0].eq     = e_eq_ff;
      rem_c[0]        = '0;
      // dividend is 2*|a|<<FRAC, divisor |b|; (2n+d)/(2d) is done as
      // quotient of 2n/d then (q+1)>>1
      num_c[0]        = {e_mag_a_ff, {FRAC_BITS{1'b0}}, 1'b0};
      den_c[0]        = {2'b00, e_mag_b_ff};
   end

   genvar gi;
   generate
      for (gi = 0; gi < CELLS; gi++) begin : g_cell
         fxa_div_cell #(.RW(RW), .NW(NW)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .ctl_in  (ctl_c[gi]),
            .rem_in  (rem_c[gi]),
            .num_in  (num_c[gi]),
            .den_in  (den_c[gi]),
            .ctl_out (ctl_c[gi+1]),
            .rem_out (rem_c[gi+1]),
            .num_out (num_c[gi+1]),
            .den_out (den_c[gi+1])
         );
      end
   endgenerate

   // ---------------- finish stage: round, saturate ----------------
   logic [NW-1:0]   q2;
   logic [2*DW-1:0] q_ext;
   logic [DW-1:0]   div_r;
   logic            div_ovf;

   // num_c[CELLS] = floor(2n/d); rounded quotient = (q2+1)>>1
   assign q2    = num_c[CELLS];
   assign q_ext = (2*DW)'(({1'b0, q2} + 1'b1) >> 1);
   always_comb div_r = sat_fn(q_ext, ctl_c[CELLS].neg, div_ovf);

   logic            f_valid_ff;
   logic [DW-1:0]   f_r_ff;
   logic            f_ovf_ff, f_dz_ff, f_eq_ff;
   logic [1:0]      f_cmp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= ctl_c[CELLS].valid;
      end
      if (advance) begin
         f_r_ff   <= ctl_c[CELLS].is_div ? div_r : ctl_c[CELLS].early;
         f_ovf_ff <= ctl_c[CELLS].is_div ? div_ovf
                                         : (ctl_c[CELLS].neg && !ctl_c[CELLS].dz);
         f_dz_ff  <= ctl_c[CELLS].dz;
         f_eq_ff  <= ctl_c[CELLS].eq;
         f_cmp_ff <= ctl_c[CELLS].cmp;
      end
   end

   // ---------------- output register ----------------
   logic            o_valid_ff;
   logic [DW-1:0]   o_r_ff;
   logic            o_ovf_ff, o_dz_ff, o_eq_ff;
   logic [1:0]      o_cmp_ff;

   assign out_free  = !o_valid_ff || !rsp_stall;
   assign advance   = out_free;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         o_valid_ff <= f_valid_ff;
      end
      if (advance) begin
         o_r_ff   <= f_r_ff;
         o_ovf_ff <= f_ovf_ff;
         o_dz_ff  <= f_dz_ff;
         o_eq_ff  <= f_eq_ff;
         o_cmp_ff <= f_cmp_ff;
      end
   end

   assign rsp_valid          = o_valid_ff;
   assign rsp_result_raw     = o_r_ff;
   assign rsp_integer_part   = 24'(($signed(o_r_ff)) >>> FRAC_BITS);
   assign rsp_a_less         = o_cmp_ff[0];
   assign rsp_a_greater      = o_cmp_ff[1];
   assign rsp_a_equal        = o_eq_ff;
   assign rsp_overflow       = o_ovf_ff;
   assign rsp_divide_by_zero = o_dz_ff;

   // ---------------- assertions ----------------
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_a_less && rsp_a_greater) && !(rsp_a_equal && rsp_a_less))
      else $error("compare flags conflict");
   a_err_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflow && rsp_divide_by_zero))
      else $error("overflow and divide by zero together");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_raw))
      else $error("stalled result changed");
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output stall");

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for the Q24.8 fixed-point arithmetic unit
// drives directed and random operations through the req_ channel, predicts
// every rsp_ beat with an exact-integer model and compares field by field
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned FRAC = 8;
   // operation codes outside the defined set
   localparam logic [3:0] OpUnknownLow  = 4'd9;
   localparam logic [3:0] OpUnknownHigh = 4'd15;

   // one predicted or observed result beat
   typedef struct packed {
      logic [31:0] raw;
      logic [23:0] ipart;
      logic        lt;
      logic        gt;
      logic        eq;
      logic        ovf;
      logic        dz;
   } alu_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [3:0]        req_operation = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_raw;
   logic signed [23:0] rsp_integer_part;
   logic              rsp_a_less;
   logic              rsp_a_greater;
   logic              rsp_a_equal;
   logic              rsp_overflow;
   logic              rsp_divide_by_zero;

   alu_result_type expected_results[$];
   int unsigned mismatch_count = 0;
   bit          stall_enable = 1'b0;
   int unsigned stall_left = 0;

   always #5 clock = ~clock;

   fixed_point_q24_8_alu_unit #(.FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_raw(rsp_result_raw), .rsp_integer_part(rsp_integer_part),
      .rsp_a_less(rsp_a_less), .rsp_a_greater(rsp_a_greater),
      .rsp_a_equal(rsp_a_equal), .rsp_overflow(rsp_overflow),
      .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   // sign-apply a magnitude and clamp into 32 signed bits
   function automatic logic [31:0] clamp_signed(input logic [63:0] mag, input bit neg,
                                                inout bit ovf);
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            ovf = 1'b1;
            return 32'h8000_0000;
         end
         return 32'd0 - mag[31:0];
      end
      if (mag > 64'h7FFF_FFFF) begin
         ovf = 1'b1;
         return 32'h7FFF_FFFF;
      end
      return mag[31:0];
   endfunction

   function automatic alu_result_type compute_alu(input logic [3:0] op,
                                                  input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      alu_result_type res;
      logic [63:0] ma, mb, prod, num, quo;
      logic [31:0] r;
      logic signed [31:0] shifted;
      bit ovf, dz, neg;
      ovf = 1'b0;
      dz = 1'b0;
      r = '0;
      ma = a < 0 ? 64'(-64'(a)) : 64'(a);
      mb = b < 0 ? 64'(-64'(b)) : 64'(b);
      neg = (a < 0) != (b < 0);
      case (op)
         fxa_pkg::OP_ADD: r = a + b;
         fxa_pkg::OP_SUB: r = a - b;
         fxa_pkg::OP_MUL: begin
            prod = ma * mb;
            quo = (prod + (64'd1 << (FRAC - 1))) >> FRAC;
            r = clamp_signed(quo, neg, ovf);
         end
         fxa_pkg::OP_DIV: begin
            if (b == 0) begin
               r = a;
               dz = 1'b1;
            end else begin
               num = ma << FRAC;
               quo = (2 * num + mb) / (2 * mb);
               r = clamp_signed(quo, neg, ovf);
            end
         end
         fxa_pkg::OP_MIN: r = (a < b) ? a : b;
         fxa_pkg::OP_MAX: r = (a > b) ? a : b;
         fxa_pkg::OP_INC: r = a + 32'd1;
         fxa_pkg::OP_DEC: r = a - 32'd1;
         fxa_pkg::OP_I2F: r = a << FRAC;
         default: r = '0;
      endcase
      shifted = $signed(r) >>> FRAC;
      res.raw = r;
      res.ipart = shifted[23:0];
      res.lt = a < b;
      res.gt = a > b;
      res.eq = a == b;
      res.ovf = ovf;
      res.dz = dz;
      return res;
   endfunction

   // random gap: mostly none or short, now and then long
   function automatic int unsigned gap_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   bit idle_enable = 1'b0;

   // send one beat; predict when it is accepted
   task automatic send_beat(input logic [3:0] op, input logic [31:0] a,
                            input logic [31:0] b);
      int unsigned gap;
      gap = idle_enable ? gap_length() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(compute_alu(op, a, b));
   endtask

   task automatic end_stimulus();
      req_valid <= 1'b0;
   endtask

   // random operand biased toward interesting corners
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 3) - 1;
         3: return 32'($signed($urandom_range(0, 4096)) - 2048);
         4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   // output side: stall runs of random length, mostly short, a few long
   always @(posedge clock) begin
      if (!stall_enable) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
      end else begin
         stall_left = gap_length();
         rsp_stall <= (stall_left != 0);
      end
   end

   // result checker: compare each accepted beat with the oldest prediction
   always @(posedge clock) begin
      alu_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_result_raw, rsp_integer_part, rsp_a_less, rsp_a_greater,
                rsp_a_equal, rsp_overflow, rsp_divide_by_zero};
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat raw=%h", got.raw);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: exp raw=%h int=%h lt%b gt%b eq%b ov%b dz%b",
                           want.raw, want.ipart, want.lt, want.gt, want.eq,
                           want.ovf, want.dz);
                  $display("          got raw=%h int=%h lt%b gt%b eq%b ov%b dz%b",
                           got.raw, got.ipart, got.lt, got.gt, got.eq,
                           got.ovf, got.dz);
               end
            end
         end
      end
   end

   // every operation on the field extremes, with zero divisor and overflow
   task automatic test_directed();
      send_beat(fxa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1);
      send_beat(fxa_pkg::OP_SUB, 32'h8000_0000, 32'd1);
      send_beat(fxa_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_beat(fxa_pkg::OP_MUL, 32'h8000_0000, 32'h0000_0100);
      send_beat(fxa_pkg::OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);
      send_beat(fxa_pkg::OP_MUL, 32'h8000_0000, 32'hFFFF_FFFF);
      send_beat(fxa_pkg::OP_DIV, 32'h0000_1234, 32'd0);
      send_beat(fxa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_beat(fxa_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0300);
      send_beat(fxa_pkg::OP_DIV, 32'hFFFF_FF00, 32'h0000_0200);
      send_beat(fxa_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000);
      send_beat(fxa_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
      send_beat(fxa_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
      send_beat(fxa_pkg::OP_MIN, 32'h0000_0005, 32'h0000_0005);
      send_beat(fxa_pkg::OP_INC, 32'h7FFF_FFFF, 32'd0);
      send_beat(fxa_pkg::OP_DEC, 32'h8000_0000, 32'd0);
      send_beat(fxa_pkg::OP_I2F, 32'h0080_0000, 32'd0);
      send_beat(fxa_pkg::OP_I2F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(OpUnknownLow, 32'h1234_5678, 32'h0000_0001);
      send_beat(OpUnknownHigh, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(fxa_pkg::OP_ADD, 32'h0, 32'h0);
   endtask

   // random operations, with idling where idle_enable and stall_enable are set
   task automatic test_random(input int unsigned count);
      logic [3:0] op;
      logic [31:0] a, b;
      for (int unsigned i = 0; i < count; i++) begin
         op = ($urandom_range(0, 19) == 0)
              ? 4'($urandom_range(OpUnknownLow, OpUnknownHigh))
              : 4'($urandom_range(fxa_pkg::OP_ADD, fxa_pkg::OP_I2F));
         a = pick_operand();
         b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
         if (op == fxa_pkg::OP_DIV && $urandom_range(0, 9) == 0) b = '0;
         send_beat(op, a, b);
      end
   endtask

   task automatic drain();
      int unsigned waited;
      end_stimulus();
      waited = 0;
      while (expected_results.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      stall_enable = 1'b0;
      repeat (FRAC + 50) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      // back-to-back with no idling, then with gaps on both sides
      test_random(300);
      idle_enable = 1'b1;
      stall_enable = 1'b1;
      test_random(800);
      drain();
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
